// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every edge outside reset.
`define PSU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent this cycle implies consequent on the next edge.
`define PSU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Types and codes shared by the scanline unfilter block.
// ----------------------------------------------------------------------------
package psu_pkg;

   localparam int ROW_PIXELS_W = 13;
   localparam int ROW_COUNT_W  = 16;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_PIXELS = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT  = CSR_INDEX_W'(1);

   // Highest filter code defined by the format
   localparam logic [7:0] FILTER_CODE_MAX = 8'd4;

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_SUB     = 3'd1,
      KIND_UP      = 3'd2,
      KIND_AVERAGE = 3'd3,
      KIND_PAETH   = 3'd4,
      KIND_UNKNOWN = 3'd5
   } filter_kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       row_end;
      logic       image_end;
   } rsp_payload_type;

endpackage

// File: src/psu_if.sv
// ----------------------------------------------------------------------------
// psu_if
// Valid/ready stream channel and configuration write channel.
// ----------------------------------------------------------------------------
interface psu_stream_if #(
   parameter type PAYLOAD_TYPE = logic [7:0]
);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface psu_csr_if;
   logic                           valid;
   logic                           ready;
   logic [psu_pkg::CSR_INDEX_W-1:0] index;
   logic [psu_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: src/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// Filter reconstruction of a decompressed PNG byte stream, RGBA8 rows.
//
//   channel   dir  payload                        accepted when
//   req_chan  in   in_byte                        valid && ready
//   rsp_chan  out  out_byte, row_end, image_end   valid && ready
//   csr_chan  in   index, wdata                   valid && ready (always ready)
//
// One byte per cycle sustained while rsp_chan is ready; an accepted sample is
// held in stage one, then in the output register. The rate is set by the
// previous-row memory, which takes one read (at accept) and one write (at
// reconstruction) every cycle. Reset clears control state only; the row
// memory is never cleared. req_chan.ready drops only while a reconstructed
// sample waits in stage one behind a full, stalled output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module png_scanline_unfilter #(
   parameter int MAX_ROW_PIXELS  = 4096,
   parameter int BYTES_PER_PIXEL = 4
) (
   input  logic          clock,
   input  logic          reset,
   psu_stream_if.sink    req_chan,
   psu_stream_if.source  rsp_chan,
   psu_csr_if.sink       csr_chan
);
   import psu_pkg::*;

   localparam int DEPTH   = MAX_ROW_PIXELS * BYTES_PER_PIXEL;
   localparam int POS_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int STR_W   = $clog2(DEPTH + 1);
   localparam int PIX_W   = $clog2(MAX_ROW_PIXELS + 1);
   localparam int CLAMP_W = (PIX_W > ROW_PIXELS_W) ? PIX_W : ROW_PIXELS_W;

   // Configuration
   logic [ROW_PIXELS_W-1:0] row_pixels_ff;
   logic [ROW_COUNT_W-1:0]  row_count_ff;
   logic                    csr_write;
   logic                    restart;

   // Row geometry
   logic [CLAMP_W-1:0] width_ext;
   logic [CLAMP_W-1:0] width_sel;
   logic [STR_W-1:0]   stride;
   logic [POS_W-1:0]   stride_last;
   logic [ROW_COUNT_W-1:0] rows;

   // Accept-side control
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   awaiting_ff, awaiting_in;
   filter_kind_type        kind_ff, kind_in;
   logic                   prior_valid_ff, prior_valid_in;
   logic [ROW_COUNT_W-1:0] row_idx_ff, row_idx_in;
   logic [ROW_COUNT_W-1:0] row_idx_next;
   logic                   accept, take_filter, take_data;
   logic                   last_in_row, img_last;
   logic [7:0]             in_v;

   // Stage one
   logic            s1_valid_ff, s1_valid_in;
   logic [POS_W-1:0] s1_pos_ff;
   filter_kind_type s1_kind_ff;
   logic            s1_prior_ff;
   logic [7:0]      s1_sample_ff;
   logic            s1_row_end_ff;
   logic            s1_img_end_ff;
   logic [7:0]      rd_data_ff;
   logic            s1_adv;
   logic            mem_we;
   logic [7:0]      up_byte;
   logic [7:0]      recon;

   logic [7:0] left_ff    [BYTES_PER_PIXEL];
   logic [7:0] up_left_ff [BYTES_PER_PIXEL];

   // Output register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff;

   logic [7:0] store_mem [DEPTH];

   // ---------------------------------------------------------------- config
   assign csr_chan.ready = 1'b1;
   assign csr_write = csr_chan.valid && csr_chan.ready;
   assign restart   = csr_write &&
                      (csr_chan.index == CSR_ROW_PIXELS || csr_chan.index == CSR_ROW_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pixels_ff <= ROW_PIXELS_W'(1);
         row_count_ff  <= ROW_COUNT_W'(1);
      end else if (csr_write) begin
         if (csr_chan.index == CSR_ROW_PIXELS) begin
            row_pixels_ff <= csr_chan.wdata[ROW_PIXELS_W-1:0];
         end
         if (csr_chan.index == CSR_ROW_COUNT) begin
            row_count_ff <= csr_chan.wdata[ROW_COUNT_W-1:0];
         end
      end
   end

   // Clamp width into 1..MAX_ROW_PIXELS
   assign width_ext = CLAMP_W'(row_pixels_ff);
   always_comb begin
      if (width_ext == '0) begin
         width_sel = CLAMP_W'(1);
      end else if (width_ext > CLAMP_W'(MAX_ROW_PIXELS)) begin
         width_sel = CLAMP_W'(MAX_ROW_PIXELS);
      end else begin
         width_sel = width_ext;
      end
   end
   assign stride      = STR_W'(width_sel) * STR_W'(BYTES_PER_PIXEL);
   assign stride_last = POS_W'(stride - STR_W'(1));
   assign rows        = (row_count_ff == '0) ? ROW_COUNT_W'(1) : row_count_ff;

   // ---------------------------------------------------------------- accept
   assign s1_adv         = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept         = req_chan.valid && req_chan.ready;
   assign take_filter    = accept && awaiting_ff;
   assign take_data      = accept && !awaiting_ff;
   assign in_v           = req_chan.data.in_byte;
   assign last_in_row    = (pos_ff == stride_last);
   assign row_idx_next   = row_idx_ff + ROW_COUNT_W'(1);
   assign img_last       = (row_idx_next >= rows) || (row_idx_next == '0);

   always_comb begin
      pos_in         = pos_ff;
      awaiting_in    = awaiting_ff;
      kind_in        = kind_ff;
      prior_valid_in = prior_valid_ff;
      row_idx_in     = row_idx_ff;
      if (restart) begin
         pos_in         = '0;
         awaiting_in    = 1'b1;
         kind_in        = KIND_NONE;
         prior_valid_in = 1'b0;
         row_idx_in     = '0;
      end else if (take_filter) begin
         kind_in     = (in_v > FILTER_CODE_MAX) ? KIND_UNKNOWN : filter_kind_type'(in_v[2:0]);
         awaiting_in = 1'b0;
         pos_in      = '0;
      end else if (take_data) begin
         if (last_in_row) begin
            pos_in      = '0;
            awaiting_in = 1'b1;
            if (img_last) begin
               row_idx_in     = '0;
               prior_valid_in = 1'b0;
            end else begin
               row_idx_in     = row_idx_next;
               prior_valid_in = 1'b1;
            end
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         awaiting_ff    <= 1'b1;
         kind_ff        <= KIND_NONE;
         prior_valid_ff <= 1'b0;
         row_idx_ff     <= '0;
      end else begin
         pos_ff         <= pos_in;
         awaiting_ff    <= awaiting_in;
         kind_ff        <= kind_in;
         prior_valid_ff <= prior_valid_in;
         row_idx_ff     <= row_idx_in;
      end
   end

   // ---------------------------------------------------------------- memory
   assign mem_we = s1_valid_ff && s1_adv;

   always_ff @(posedge clock) begin
      if (take_data) begin
         rd_data_ff <= store_mem[pos_ff];
      end
      if (mem_we) begin
         store_mem[s1_pos_ff] <= recon;
      end
   end

   // ---------------------------------------------------------------- stage one
   assign s1_valid_in = take_data ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_data) begin
         s1_pos_ff     <= pos_ff;
         s1_kind_ff    <= kind_ff;
         s1_prior_ff   <= prior_valid_ff;
         s1_sample_ff  <= in_v;
         s1_row_end_ff <= last_in_row;
         s1_img_end_ff <= last_in_row && img_last;
      end
   end

   // Above byte reads as zero in the first row of an image
   assign up_byte = s1_prior_ff ? rd_data_ff : 8'd0;

   psu_predict u_predict (
      .kind    (s1_kind_ff),
      .sample  (s1_sample_ff),
      .left    (left_ff[0]),
      .up      (up_byte),
      .up_left (up_left_ff[0]),
      .recon   (recon)
   );

   // Left and above-left history; a new filter byte starts the row at zero
   always_ff @(posedge clock) begin
      if (reset || restart || take_filter) begin
         for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
            left_ff[i]    <= 8'd0;
            up_left_ff[i] <= 8'd0;
         end
      end else if (mem_we) begin
         for (int i = 0; i < BYTES_PER_PIXEL - 1; i++) begin
            left_ff[i]    <= left_ff[i+1];
            up_left_ff[i] <= up_left_ff[i+1];
         end
         left_ff[BYTES_PER_PIXEL-1]    <= recon;
         up_left_ff[BYTES_PER_PIXEL-1] <= up_byte;
      end
   end

   // ---------------------------------------------------------------- output
   assign out_valid_in = s1_adv ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         out_data_ff.out_byte  <= recon;
         out_data_ff.row_end   <= s1_row_end_ff;
         out_data_ff.image_end <= s1_img_end_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   // ---------------------------------------------------------------- checks
   `PSU_ASSERT(a_no_rw_collision, !(take_data && mem_we) || (pos_ff != s1_pos_ff), "row memory read and write hit the same entry")
   `PSU_ASSERT(a_pos_in_row, awaiting_ff || (pos_ff <= stride_last), "byte position past end of row")
   `PSU_ASSERT(a_image_end_row_end, !(rsp_chan.valid && rsp_chan.data.image_end) || rsp_chan.data.row_end, "image end without row end")
   `PSU_ASSERT_NEXT(a_row_end_awaits, take_data && last_in_row, awaiting_ff, "no filter byte expected after last sample of row")

endmodule

// File: src/psu_predict.sv
// ----------------------------------------------------------------------------
// psu_predict
// Predictor select and sample reconstruction for one byte (None, Sub, Up,
// Average, Paeth).
// ----------------------------------------------------------------------------
module psu_predict (
   input  psu_pkg::filter_kind_type kind,
   input  logic [7:0]               sample,
   input  logic [7:0]               left,
   input  logic [7:0]               up,
   input  logic [7:0]               up_left,
   output logic [7:0]               recon
);
   import psu_pkg::*;

   function automatic logic [9:0] mag10(input logic signed [9:0] x);
      mag10 = x[9] ? 10'(-x) : 10'(x);
   endfunction

   logic signed [9:0] s_a, s_b, s_c;
   logic signed [9:0] d_bc, d_ac, d_p;
   logic [9:0]        pa, pb, pc;
   logic [8:0]        avg_sum;
   logic [7:0]        paeth_pick;
   logic [7:0]        pred;

   assign s_a = $signed({2'b00, left});
   assign s_b = $signed({2'b00, up});
   assign s_c = $signed({2'b00, up_left});

   // p = a + b - c, so |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
   assign d_bc = s_b - s_c;
   assign d_ac = s_a - s_c;
   assign d_p  = d_bc + d_ac;
   assign pa   = mag10(d_bc);
   assign pb   = mag10(d_ac);
   assign pc   = mag10(d_p);

   assign avg_sum = {1'b0, left} + {1'b0, up};

   always_comb begin
      if (pa <= pb && pa <= pc) begin
         paeth_pick = left;
      end else if (pb <= pc) begin
         paeth_pick = up;
      end else begin
         paeth_pick = up_left;
      end
   end

   always_comb begin
      case (kind)
         KIND_SUB:     pred = left;
         KIND_UP:      pred = up;
         KIND_AVERAGE: pred = avg_sum[8:1];
         KIND_PAETH:   pred = paeth_pick;
         default:      pred = 8'd0;
      endcase
   end

   assign recon = sample + pred;

endmodule

// File: verif/psu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_checker
// Watches the request, result and register channels of the scanline
// unfilter, rebuilds each sample from its own copy of the row state and
// compares every result item field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module psu_checker
   import psu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   psu_stream_if   req_mon,
   psu_stream_if   rsp_mon,
   psu_csr_if      csr_mon,
   output int      mismatches,
   output int      outstanding
);

   localparam int ROW_LIMIT     = 4096;
   localparam int PIXEL_BYTES   = 4;
   localparam int ROW_BYTES_MAX = ROW_LIMIT * PIXEL_BYTES;

   logic [ROW_PIXELS_W-1:0] width_reg;
   logic [ROW_COUNT_W-1:0]  rows_reg;

   logic [7:0]      above_row [0:ROW_BYTES_MAX-1];
   int              column;
   bit              want_filter;
   filter_kind_type kind;
   bit              above_ok;
   logic [7:0]      left_hist  [PIXEL_BYTES];
   logic [7:0]      upleft_hist[PIXEL_BYTES];
   logic [15:0]     row_no;

   rsp_payload_type sample_q[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic restart_image();
      column      = 0;
      want_filter = 1'b1;
      kind        = KIND_NONE;
      above_ok    = 1'b0;
      row_no      = '0;
      foreach (left_hist[i]) begin
         left_hist[i]   = '0;
         upleft_hist[i] = '0;
      end
   endtask

   function automatic int row_bytes();
      int w;
      w = int'(width_reg);
      if (w == 0) w = 1;
      if (w > ROW_LIMIT) w = ROW_LIMIT;
      return w * PIXEL_BYTES;
   endfunction

   function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int p, pa, pb, pc;
      p  = int'(a) + int'(b) - int'(c);
      pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
      pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
      pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
   endfunction

   task automatic report_bad(string what, logic [7:0] got, logic [7:0] want);
      mismatches++;
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
   endtask

   task automatic take_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      if (idx == CSR_ROW_PIXELS) begin
         width_reg = val[ROW_PIXELS_W-1:0];
         restart_image();
      end else if (idx == CSR_ROW_COUNT) begin
         rows_reg = val[ROW_COUNT_W-1:0];
         restart_image();
      end
   endtask

   task automatic rebuild_sample(logic [7:0] v);
      rsp_payload_type item;
      int              stride, rows, pos;
      logic [7:0]      a, b, c, guess, recon;
      stride = row_bytes();
      rows   = (rows_reg == 0) ? 1 : int'(rows_reg);
      if (want_filter) begin
         kind        = (v > FILTER_CODE_MAX) ? KIND_UNKNOWN : filter_kind_type'(v[2:0]);
         want_filter = 1'b0;
         column      = 0;
         foreach (left_hist[i]) begin
            left_hist[i]   = '0;
            upleft_hist[i] = '0;
         end
      end else begin
         pos = (column >= ROW_BYTES_MAX) ? ROW_BYTES_MAX - 1 : column;
         a   = left_hist[0];
         c   = upleft_hist[0];
         b   = above_ok ? above_row[pos] : 8'h00;
         case (kind)
            KIND_SUB:     guess = a;
            KIND_UP:      guess = b;
            KIND_AVERAGE: guess = 8'((9'(a) + 9'(b)) >> 1);
            KIND_PAETH:   guess = paeth_pick(a, b, c);
            default:      guess = 8'h00;
         endcase
         recon          = v + guess;
         above_row[pos] = recon;
         for (int i = 0; i < PIXEL_BYTES - 1; i++) begin
            left_hist[i]   = left_hist[i+1];
            upleft_hist[i] = upleft_hist[i+1];
         end
         left_hist[PIXEL_BYTES-1]   = recon;
         upleft_hist[PIXEL_BYTES-1] = b;

         item.out_byte  = recon;
         item.row_end   = 1'b0;
         item.image_end = 1'b0;
         column = pos + 1;
         if (column >= stride) begin
            item.row_end = 1'b1;
            column       = 0;
            want_filter  = 1'b1;
            above_ok     = 1'b1;
            row_no       = row_no + 16'd1;
            if (int'(row_no) >= rows || row_no == 16'd0) begin
               item.image_end = 1'b1;
               row_no         = '0;
               above_ok       = 1'b0;
            end
         end
         sample_q.push_back(item);
      end
   endtask

   task automatic check_sample(rsp_payload_type got);
      rsp_payload_type want;
      if (sample_q.size() == 0) begin
         report_bad("result with nothing pending, out_byte", got.out_byte, 8'h00);
      end else begin
         want = sample_q.pop_front();
         if (got.out_byte !== want.out_byte)
            report_bad("out_byte", got.out_byte, want.out_byte);
         if (got.row_end !== want.row_end)
            report_bad("row_end", 8'(got.row_end), 8'(want.row_end));
         if (got.image_end !== want.image_end)
            report_bad("image_end", 8'(got.image_end), 8'(want.image_end));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg = ROW_PIXELS_W'(1);
         rows_reg  = ROW_COUNT_W'(1);
         restart_image();
         sample_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready)
            take_write(csr_mon.index, csr_mon.wdata);
         if (req_mon.valid && req_mon.ready)
            rebuild_sample(req_mon.data.in_byte);
         if (rsp_mon.valid && rsp_mon.ready)
            check_sample(rsp_mon.data);
      end
      outstanding = sample_q.size();
   end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives filtered PNG row streams into the scanline unfilter under several
// widths, row counts and idle patterns; the checker beside the block predicts
// and compares every reconstructed sample.
// ----------------------------------------------------------------------------
module tb_top;
   import psu_pkg::*;

   localparam int              STALL_LIMIT  = 3000;
   localparam int              SETTLE_TICKS = 8;
   localparam int              LONG_HOLD    = 250;
   localparam logic [7:0]      FILTER_JUNK  = 8'hFF;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = '1;

   logic clock;
   logic reset;

   psu_stream_if #(.PAYLOAD_TYPE(req_payload_type)) req_bus ();
   psu_stream_if #(.PAYLOAD_TYPE(rsp_payload_type)) rsp_bus ();
   psu_csr_if                                       csr_bus ();

   int mismatches;
   int outstanding;

   int send_idle;
   int recv_idle;
   bit hold_ask;

   int gen_col;
   int gen_stride;

   int quiet;

   png_scanline_unfilter DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   psu_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int  hold_left;
      bit  hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_ask && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_byte(logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.data.in_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // filter bytes leave no result, so keep waiting after the drain
   task automatic settle();
      wait_drained();
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= val;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_filter();
      int r;
      r = $urandom_range(99);
      if (r < 80) return 8'($urandom_range(int'(KIND_PAETH), int'(KIND_NONE)));
      if (r < 88) return 8'(KIND_UNKNOWN);
      return 8'($urandom_range(255, 6));
   endfunction

   function automatic logic [7:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 8'h00;
      if (r < 20) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // every row: one filter byte, then stride sample bytes
   function automatic logic [7:0] next_stream_byte();
      logic [7:0] b;
      b = (gen_col == 0) ? pick_filter() : pick_sample();
      gen_col = (gen_col >= gen_stride) ? 0 : gen_col + 1;
      return b;
   endfunction

   task automatic run_phase(logic [CSR_DATA_W-1:0] width, logic [CSR_DATA_W-1:0] rows,
                            int n, int s_idle, int r_idle, bit long_hold, bit pause,
                            bit poke);
      int w;
      settle();
      send_idle = s_idle;
      recv_idle = r_idle;
      write_reg(CSR_ROW_PIXELS, width);
      write_reg(CSR_ROW_COUNT, rows);
      w = int'(width[ROW_PIXELS_W-1:0]);
      if (w == 0) w = 1;
      if (w > 4096) w = 4096;
      gen_stride = w * 4;
      gen_col    = 0;
      for (int k = 0; k < n; k++) begin
         if (long_hold && k == n / 4) hold_ask = 1'b1;
         if ((pause || poke) && k == n / 2) begin
            // stop sending until every sample is back
            wait_drained();
            if (poke) begin
               repeat (SETTLE_TICKS) @(posedge clock);
               write_reg(CSR_UNMAPPED, 16'($urandom_range(65535)));
            end
         end
         push_byte(next_stream_byte());
      end
   endtask

   initial begin
      logic [7:0] first_image [$];
      logic [7:0] four_rows   [$];
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.wdata <= '0;
      send_idle = 8;
      recv_idle = 55;
      hold_ask  = 1'b0;
      gen_col   = 0;
      gen_stride = 4;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset widths: one pixel, one row, unknown filter passes data through
      first_image = '{FILTER_JUNK, 8'h00, 8'hFF, 8'h7F, 8'h80};
      foreach (first_image[i]) push_byte(first_image[i]);
      settle();
      write_reg(CSR_ROW_COUNT, 16'd4);
      four_rows = '{8'(KIND_SUB),     8'hFF, 8'h01, 8'h00, 8'hFF,
                    8'(KIND_UP),      8'h80, 8'hFF, 8'h01, 8'h00,
                    8'(KIND_AVERAGE), 8'hFF, 8'hFF, 8'h00, 8'h01,
                    8'(KIND_PAETH),   8'h01, 8'h80, 8'hFF, 8'h7F};
      foreach (four_rows[i]) push_byte(four_rows[i]);

      run_phase(16'd2, 16'd3, 130, 8, 55, 1'b1, 1'b0, 1'b0);
      run_phase(16'd0, 16'd0, 50, 8, 55, 1'b0, 1'b0, 1'b0);
      run_phase(16'($urandom_range(6, 1)), 16'($urandom_range(5, 1)), 100, 8, 55,
                1'b0, 1'b0, 1'b0);
      run_phase(16'd3, 16'hFFFF, 120, 55, 8, 1'b0, 1'b0, 1'b1);
      run_phase(16'hE005, 16'd2, 100, 55, 8, 1'b0, 1'b1, 1'b0);
      run_phase(16'h1FFF, 16'd2, 30, 0, 0, 1'b0, 1'b0, 1'b0);
      run_phase(16'($urandom_range(8, 1)), 16'($urandom_range(4, 1)), 80, 0, 0,
                1'b0, 1'b0, 1'b0);
      run_phase(16'd4096, 16'd1, 30, 0, 0, 1'b0, 1'b0, 1'b0);

      settle();
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
